@@ rtl/sed_pkg.sv @@
// Shared types, widths and constants of the scan-line edge triple detector.
`default_nettype none

package sed_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_OUT_W  = 10;
    localparam int SCORE_W    = 18;
    localparam int MEAN_W     = 16;
    localparam int SEED_SUM_W = 10;
    localparam int DEV_W      = 18;
    localparam int MUL_A_W    = 8;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = 26;
    localparam int DIST_W     = 5;
    localparam int DIST_MAX   = 31;

    localparam int MAX_LINE_DEF = 1024;
    localparam int SEED_LEN     = 4;

    localparam logic [CFG_W-1:0] EDGE_THRESHOLD_RST = 8'd127;
    localparam logic [CFG_W-1:0] MEAN_GAIN_RST      = 8'd77;
    localparam logic [CFG_W-1:0] SPACING_WEIGHT_RST = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_THRESHOLD = 2'd0,
        REG_MEAN_GAIN      = 2'd1,
        REG_SPACING_WEIGHT = 2'd2
    } sed_reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_MUL_GAIN,
        ST_UPDATE,
        ST_MUL_SQUARE,
        ST_MUL_PENALTY,
        ST_SCORE,
        ST_DONE
    } sed_state_t;

    typedef enum logic [1:0] {
        MSEL_GAIN,
        MSEL_SQUARE,
        MSEL_PENALTY
    } sed_mul_sel_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic         in_ready;
        logic         mul_en;
        sed_mul_sel_t mul_sel;
        logic         seed_en;
        logic         update_en;
        logic         spacing_en;
        logic         score_en;
        logic         finish_en;
    } sed_ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_fire;
        logic seeding;
        logic new_edge;
        logic score_due;
        logic last_item;
        logic out_busy;
    } sed_stat_t;

endpackage

`default_nettype wire

@@ rtl/sed_stream_if.sv @@
// Valid/ready stream interfaces for the sample input and the line result.
`default_nettype none

interface sed_in_if;
    logic                         valid;
    logic                         ready;
    logic [sed_pkg::SAMPLE_W-1:0] sample;
    logic                         last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface sed_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [sed_pkg::POS_OUT_W-1:0] first_pos;
    logic [sed_pkg::POS_OUT_W-1:0] second_pos;
    logic [sed_pkg::POS_OUT_W-1:0] third_pos;
    logic [sed_pkg::SCORE_W-1:0]   best_score;

    modport source (output valid, output found, output first_pos, output second_pos,
                    output third_pos, output best_score, input ready);
    modport sink   (input valid, input found, input first_pos, input second_pos,
                    input third_pos, input best_score, output ready);
endinterface

`default_nettype wire

@@ rtl/sed_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none

module sed_mul (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic        [sed_pkg::MUL_A_W-1:0]  a,
    input  wire logic signed [sed_pkg::MUL_B_W-1:0]  b,
    output      logic signed [sed_pkg::PROD_W-1:0]   prod_reg
);

    logic signed [sed_pkg::PROD_W:0] full;

    // The unsigned operand gains a zero sign bit; the product always fits PROD_W bits.
    assign full = $signed({1'b0, a}) * b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full[sed_pkg::PROD_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/sed_seq.sv @@
// Sequencer that steps one sample through the shared multiplier and update steps.
`default_nettype none

module sed_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sed_pkg::sed_stat_t stat,
    output      sed_pkg::sed_ctrl_t ctrl
);

    sed_pkg::sed_state_t state_reg;
    sed_pkg::sed_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sed_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sed_pkg::ST_IDLE:
            begin
                if (stat.in_fire)
                begin
                    state_next = stat.seeding ? sed_pkg::ST_SEED : sed_pkg::ST_MUL_GAIN;
                end
            end
            sed_pkg::ST_SEED:        state_next = sed_pkg::ST_DONE;
            sed_pkg::ST_MUL_GAIN:    state_next = sed_pkg::ST_UPDATE;
            sed_pkg::ST_UPDATE:
            begin
                if (stat.new_edge && stat.score_due)
                begin
                    state_next = sed_pkg::ST_MUL_SQUARE;
                end
                else
                begin
                    state_next = sed_pkg::ST_DONE;
                end
            end
            sed_pkg::ST_MUL_SQUARE:  state_next = sed_pkg::ST_MUL_PENALTY;
            sed_pkg::ST_MUL_PENALTY: state_next = sed_pkg::ST_SCORE;
            sed_pkg::ST_SCORE:       state_next = sed_pkg::ST_DONE;
            sed_pkg::ST_DONE:
            begin
                if (!(stat.last_item && stat.out_busy))
                begin
                    state_next = sed_pkg::ST_IDLE;
                end
            end
            default:                 state_next = sed_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.mul_sel = sed_pkg::MSEL_GAIN;
        case (state_reg)
            sed_pkg::ST_IDLE:        ctrl.in_ready = 1'b1;
            sed_pkg::ST_SEED:        ctrl.seed_en = 1'b1;
            sed_pkg::ST_MUL_GAIN:    ctrl.mul_en = 1'b1;
            sed_pkg::ST_UPDATE:      ctrl.update_en = 1'b1;
            sed_pkg::ST_MUL_SQUARE:
            begin
                ctrl.mul_en     = 1'b1;
                ctrl.mul_sel    = sed_pkg::MSEL_SQUARE;
                ctrl.spacing_en = 1'b1;
            end
            sed_pkg::ST_MUL_PENALTY:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = sed_pkg::MSEL_PENALTY;
            end
            sed_pkg::ST_SCORE:       ctrl.score_en = 1'b1;
            sed_pkg::ST_DONE:        ctrl.finish_en = !(stat.last_item && stat.out_busy);
            default:                 ctrl = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/scanline_edge_triple_detector.sv @@
// Top level of the scan-line edge triple detector: datapath, registers and result stage.
//
//   Channel  Dir  Handshake          Payload
//   pixels   in   valid/ready        sample[7:0], last
//   result   out  valid/ready        found, first_pos, second_pos, third_pos, best_score
//   cfg      in   cfg_we (no wait)   cfg_index[1:0], cfg_data[7:0]
//
// While the running mean is being seeded a request takes the seed step; an ordinary
// sample takes the gain pass through the single shared multiplier and the update, and a
// new transition that completes a triple adds the square and penalty passes and the score.
// On the final sample of a line the sequencer waits while the result register is
// still held by a stalled consumer. Reset clears all line state and restores the
// register defaults; no clearing pass is needed.
`default_nettype none

module scanline_edge_triple_detector #(
    parameter int MAX_LINE = sed_pkg::MAX_LINE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    sed_in_if.sink                               pixels,
    sed_out_if.source                            result,
    input  wire logic                            cfg_we,
    input  wire logic [sed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sed_pkg::CFG_W-1:0]       cfg_data
);

    localparam int PW = $clog2(MAX_LINE);

    // Configuration registers.
    logic [sed_pkg::CFG_W-1:0] thr_reg;
    logic [sed_pkg::CFG_W-1:0] gain_reg;
    logic [sed_pkg::CFG_W-1:0] weight_reg;

    // Captured request.
    logic [sed_pkg::SAMPLE_W-1:0] sample_reg;
    logic                         last_reg;

    // Line state.
    logic [PW-1:0]                  pos_reg;
    logic [sed_pkg::SEED_SUM_W-1:0] seed_sum_reg;
    logic [sed_pkg::MEAN_W-1:0]     mean_reg;
    logic                           in_edge_reg;
    logic [PW-1:0]                  hpos0_reg;
    logic [PW-1:0]                  hpos1_reg;
    logic [sed_pkg::MEAN_W-1:0]     hstr0_reg;
    logic [sed_pkg::MEAN_W-1:0]     hstr1_reg;
    logic [1:0]                     edges_seen_reg;
    logic [sed_pkg::SCORE_W-1:0]    best_reg;
    logic [PW-1:0]                  bpos0_reg;
    logic [PW-1:0]                  bpos1_reg;
    logic [PW-1:0]                  bpos2_reg;

    // Working registers of the scoring steps.
    logic [sed_pkg::MEAN_W-1:0] mag_reg;
    logic                       far_reg;

    // Result register.
    logic                          out_valid_reg;
    logic                          out_found_reg;
    logic [sed_pkg::POS_OUT_W-1:0] out_p0_reg;
    logic [sed_pkg::POS_OUT_W-1:0] out_p1_reg;
    logic [sed_pkg::POS_OUT_W-1:0] out_p2_reg;
    logic [sed_pkg::SCORE_W-1:0]   out_score_reg;

    sed_pkg::sed_ctrl_t ctrl;
    sed_pkg::sed_stat_t stat;

    logic                                in_fire;
    logic                                out_busy;
    logic                                seeding;
    logic [sed_pkg::SEED_SUM_W-1:0]      seed_sum_next;
    logic signed [sed_pkg::DEV_W-1:0]    dev;
    logic [sed_pkg::DEV_W-1:0]           dev_abs;
    logic [sed_pkg::MEAN_W-1:0]          mag;
    logic                                edge_hit;
    logic                                new_edge;
    logic signed [sed_pkg::DEV_W-1:0]    gain_step;
    logic signed [sed_pkg::DEV_W:0]      mean_sum;
    logic [sed_pkg::MEAN_W-1:0]          mean_next;
    logic signed [PW+2:0]                spacing;
    logic [PW+1:0]                       spacing_abs;
    logic                                far;
    logic [sed_pkg::DIST_W-1:0]          spread;
    logic [sed_pkg::MUL_A_W-1:0]         mul_a;
    logic signed [sed_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [sed_pkg::PROD_W-1:0]   prod;
    logic [sed_pkg::SCORE_W-1:0]         str_sum;
    logic [sed_pkg::PROD_W-1:0]          penalty;
    logic [sed_pkg::PROD_W:0]            bar;
    logic [sed_pkg::PROD_W:0]            score;
    logic                                keep;
    logic                                shift_hold;
    logic [sed_pkg::MEAN_W-1:0]          hold_str;
    logic                                load_out;
    logic [PW+sed_pkg::POS_OUT_W-1:0]    ext0;
    logic [PW+sed_pkg::POS_OUT_W-1:0]    ext1;
    logic [PW+sed_pkg::POS_OUT_W-1:0]    ext2;

    assign in_fire  = pixels.valid && pixels.ready;
    assign out_busy = out_valid_reg && !result.ready;
    assign seeding  = pos_reg < PW'(sed_pkg::SEED_LEN);

    assign stat.in_fire   = in_fire;
    assign stat.seeding   = seeding;
    assign stat.new_edge  = new_edge;
    assign stat.score_due = edges_seen_reg[1];
    assign stat.last_item = last_reg;
    assign stat.out_busy  = out_busy;

    sed_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign pixels.ready = ctrl.in_ready;

    // Seeding: the mean becomes the floor of the average of the first samples.
    assign seed_sum_next = seed_sum_reg + sed_pkg::SEED_SUM_W'(sample_reg);

    // Deviation of the sample from the running mean, both in Q8.8.
    assign dev      = $signed({2'b00, sample_reg, 8'h00}) - $signed({2'b00, mean_reg});
    assign dev_abs  = dev[sed_pkg::DEV_W-1] ? sed_pkg::DEV_W'(-dev) : sed_pkg::DEV_W'(dev);
    assign mag      = dev_abs[sed_pkg::MEAN_W-1:0];
    assign edge_hit = {2'b00, dev_abs[sed_pkg::MEAN_W-1:0]} >= {2'b00, thr_reg, 8'h00};
    assign new_edge = edge_hit && !in_edge_reg;

    // The arithmetic shift of the product gives the floor of gain * dev / 256.
    assign gain_step = prod[sed_pkg::PROD_W-1:8];
    assign mean_sum  = $signed({3'b000, mean_reg}) + {gain_step[sed_pkg::DEV_W-1], gain_step};

    always_comb
    begin
        if (mean_sum[sed_pkg::DEV_W])
        begin
            mean_next = '0;
        end
        else if (mean_sum[sed_pkg::DEV_W-1:sed_pkg::MEAN_W] != '0)
        begin
            mean_next = '1;
        end
        else
        begin
            mean_next = mean_sum[sed_pkg::MEAN_W-1:0];
        end
    end

    // Spacing difference of the triple. Beyond DIST_MAX any non-zero weight gives a
    // penalty far above the largest strength sum, so the distance is clamped there.
    assign spacing     = $signed({3'b000, pos_reg}) - $signed({2'b00, hpos1_reg, 1'b0})
                       + $signed({3'b000, hpos0_reg});
    assign spacing_abs = spacing[PW+2] ? (PW+2)'(-spacing) : (PW+2)'(spacing);
    assign far         = spacing_abs > (PW+2)'(sed_pkg::DIST_MAX);
    assign spread      = far ? sed_pkg::DIST_W'(sed_pkg::DIST_MAX)
                             : sed_pkg::DIST_W'(spacing_abs);

    always_comb
    begin
        case (ctrl.mul_sel)
            sed_pkg::MSEL_GAIN:
            begin
                mul_a = gain_reg;
                mul_b = dev;
            end
            sed_pkg::MSEL_SQUARE:
            begin
                mul_a = sed_pkg::MUL_A_W'(spread);
                mul_b = $signed(sed_pkg::MUL_B_W'(spread));
            end
            sed_pkg::MSEL_PENALTY:
            begin
                mul_a = weight_reg;
                mul_b = $signed(prod[sed_pkg::MUL_B_W-1:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    sed_mul u_mul (
        .clk      (clk),
        .en       (ctrl.mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    // Score step: the product now holds weight * spread^2, scaled by 256 here.
    assign str_sum = sed_pkg::SCORE_W'(hstr0_reg) + sed_pkg::SCORE_W'(hstr1_reg)
                   + sed_pkg::SCORE_W'(mag_reg);
    assign penalty = {prod[sed_pkg::SCORE_W-1:0], 8'h00};
    assign bar     = (sed_pkg::PROD_W+1)'(penalty) + (sed_pkg::PROD_W+1)'(best_reg);
    assign score   = (sed_pkg::PROD_W+1)'(str_sum) - (sed_pkg::PROD_W+1)'(penalty);
    assign keep    = !(far_reg && (weight_reg != '0))
                   && ((sed_pkg::PROD_W+1)'(str_sum) > bar);

    assign shift_hold = (ctrl.update_en && new_edge && !edges_seen_reg[1]) || ctrl.score_en;
    assign hold_str   = ctrl.score_en ? mag_reg : mag;
    assign load_out   = ctrl.finish_en && last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= sed_pkg::EDGE_THRESHOLD_RST;
            gain_reg   <= sed_pkg::MEAN_GAIN_RST;
            weight_reg <= sed_pkg::SPACING_WEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sed_pkg::REG_EDGE_THRESHOLD: thr_reg    <= cfg_data;
                sed_pkg::REG_MEAN_GAIN:      gain_reg   <= cfg_data;
                sed_pkg::REG_SPACING_WEIGHT: weight_reg <= cfg_data;
                default:                     thr_reg    <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= pixels.sample;
        end
        if (ctrl.update_en)
        begin
            mag_reg <= mag;
        end
        if (ctrl.spacing_en)
        begin
            far_reg <= far;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg       <= 1'b0;
            pos_reg        <= '0;
            seed_sum_reg   <= '0;
            mean_reg       <= '0;
            in_edge_reg    <= 1'b0;
            hpos0_reg      <= '0;
            hpos1_reg      <= '0;
            hstr0_reg      <= '0;
            hstr1_reg      <= '0;
            edges_seen_reg <= '0;
            best_reg       <= '0;
            bpos0_reg      <= '0;
            bpos1_reg      <= '0;
            bpos2_reg      <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                last_reg <= pixels.last;
            end
            if (ctrl.seed_en)
            begin
                seed_sum_reg <= seed_sum_next;
                if (pos_reg == PW'(sed_pkg::SEED_LEN - 1))
                begin
                    mean_reg <= {seed_sum_next[sed_pkg::SEED_SUM_W-1:2], 8'h00};
                end
            end
            if (ctrl.update_en)
            begin
                mean_reg    <= mean_next;
                in_edge_reg <= edge_hit;
            end
            if (ctrl.score_en && keep)
            begin
                best_reg  <= score[sed_pkg::SCORE_W-1:0];
                bpos0_reg <= hpos0_reg;
                bpos1_reg <= hpos1_reg;
                bpos2_reg <= pos_reg;
            end
            if (shift_hold)
            begin
                hpos0_reg <= hpos1_reg;
                hstr0_reg <= hstr1_reg;
                hpos1_reg <= pos_reg;
                hstr1_reg <= hold_str;
                if (edges_seen_reg != 2'd3)
                begin
                    edges_seen_reg <= edges_seen_reg + 2'd1;
                end
            end
            if (load_out)
            begin
                // End of line: the result is taken and the line starts afresh.
                pos_reg        <= '0;
                seed_sum_reg   <= '0;
                mean_reg       <= '0;
                in_edge_reg    <= 1'b0;
                hpos0_reg      <= '0;
                hpos1_reg      <= '0;
                hstr0_reg      <= '0;
                hstr1_reg      <= '0;
                edges_seen_reg <= '0;
                best_reg       <= '0;
                bpos0_reg      <= '0;
                bpos1_reg      <= '0;
                bpos2_reg      <= '0;
            end
            else if (ctrl.finish_en && (pos_reg != PW'(MAX_LINE - 1)))
            begin
                pos_reg <= pos_reg + PW'(1);
            end
        end
    end

    // Positions are reported in their low ten bits.
    assign ext0 = (PW + sed_pkg::POS_OUT_W)'(bpos0_reg);
    assign ext1 = (PW + sed_pkg::POS_OUT_W)'(bpos1_reg);
    assign ext2 = (PW + sed_pkg::POS_OUT_W)'(bpos2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_found_reg <= best_reg != '0;
            out_p0_reg    <= ext0[sed_pkg::POS_OUT_W-1:0];
            out_p1_reg    <= ext1[sed_pkg::POS_OUT_W-1:0];
            out_p2_reg    <= ext2[sed_pkg::POS_OUT_W-1:0];
            out_score_reg <= best_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.found      = out_found_reg;
    assign result.first_pos  = out_p0_reg;
    assign result.second_pos = out_p1_reg;
    assign result.third_pos  = out_p2_reg;
    assign result.best_score = out_score_reg;

    // No transition can be held while the mean is still being seeded.
    a_seed_no_edges : assert property (@(posedge clk) disable iff (!rst_n)
        seeding |-> (edges_seen_reg == 2'd0) && (best_reg == '0))
        else $error("transition state not clear during seeding");

    // The block is busy in the cycle after it takes a request.
    a_busy_after_fire : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !pixels.ready)
        else $error("ready again straight after a request");

    // A fresh result only follows the final sample of a line.
    a_result_from_last : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(last_reg))
        else $error("result raised without a final sample");

    // The found flag agrees with the reported score.
    a_found_matches : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_found_reg == (out_score_reg != '0)))
        else $error("found flag disagrees with score");

endmodule

`default_nettype wire

@@ bench/triple_verdict_checker.sv @@
// Line-report predictor and scoreboard for the scan-line edge triple detector.
module triple_verdict_checker
    import sed_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    sed_in_if                    pixels,
    sed_out_if                   result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   lines_checked,
    output int                   best_updates
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                 found;
        logic [POS_OUT_W-1:0] first_pos;
        logic [POS_OUT_W-1:0] second_pos;
        logic [POS_OUT_W-1:0] third_pos;
        logic [SCORE_W-1:0]   best_score;
    } line_report_t;

    line_report_t line_reports_due[$];

    logic [CFG_W-1:0]   thresh_reg;
    logic [CFG_W-1:0]   gain_reg;
    logic [CFG_W-1:0]   weight_reg;

    int                 line_pos;
    int                 seed_total;
    logic [MEAN_W-1:0]  mean_q88;
    bit                 in_transition;
    int                 held_pos[2];
    int                 held_strength[2];
    int                 edge_count;
    logic [SCORE_W-1:0] best_val;
    int                 best_pos[3];

    function automatic void restart_line();
        line_pos      = 0;
        seed_total    = 0;
        mean_q88      = '0;
        in_transition = 1'b0;
        held_pos      = '{0, 0};
        held_strength = '{0, 0};
        edge_count    = 0;
        best_val      = '0;
        best_pos      = '{0, 0, 0};
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // A new transition closes a triple with the two held ones once two are held.
    task automatic score_edge_triple(input int at, input longint strength);
        longint spread;
        longint total;
        longint score;
        if (edge_count >= 2)
        begin
            spread = (longint'(at) - longint'(held_pos[1]))
                   - (longint'(held_pos[1]) - longint'(held_pos[0]));
            if (spread < 0)
                spread = -spread;
            total = longint'(held_strength[0]) + longint'(held_strength[1]) + strength;
            score = total - longint'(weight_reg) * spread * spread * 256;
            if (score > longint'(best_val))
            begin
                best_val    = score[SCORE_W-1:0];
                best_pos[0] = held_pos[0];
                best_pos[1] = held_pos[1];
                best_pos[2] = at;
                best_updates++;
            end
        end
        held_pos[0]      = held_pos[1];
        held_strength[0] = held_strength[1];
        held_pos[1]      = at;
        held_strength[1] = int'(strength);
        if (edge_count < 3)
            edge_count++;
    endtask

    task automatic advance_scanline(input logic [SAMPLE_W-1:0] sample, input logic last);
        longint       dev;
        longint       moved;
        longint       mag;
        line_report_t report;
        if (line_pos < SEED_LEN)
        begin
            seed_total += int'(sample);
            if (line_pos == SEED_LEN - 1)
                mean_q88 = MEAN_W'((seed_total / SEED_LEN) * 256);
        end
        else
        begin
            dev   = longint'(sample) * 256 - longint'(mean_q88);
            // The arithmetic shift floors towards minus infinity, as the gain step needs.
            moved = longint'(mean_q88) + ((longint'(gain_reg) * dev) >>> 8);
            mag   = (dev < 0) ? -dev : dev;
            if (moved < 0)
                moved = 0;
            else if (moved > 65535)
                moved = 65535;
            mean_q88 = moved[MEAN_W-1:0];
            if (mag >= longint'(thresh_reg) * 256)
            begin
                if (!in_transition)
                    score_edge_triple(line_pos, mag);
                in_transition = 1'b1;
            end
            else
            begin
                in_transition = 1'b0;
            end
        end
        if (line_pos < MAX_LINE_DEF - 1)
            line_pos++;
        if (last)
        begin
            report.found      = (best_val != '0);
            report.first_pos  = POS_OUT_W'(best_pos[0]);
            report.second_pos = POS_OUT_W'(best_pos[1]);
            report.third_pos  = POS_OUT_W'(best_pos[2]);
            report.best_score = best_val;
            line_reports_due.insert(line_reports_due.size(), report);
            restart_line();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_report_t want;
        if (!rst_n)
        begin
            thresh_reg = EDGE_THRESHOLD_RST;
            gain_reg   = MEAN_GAIN_RST;
            weight_reg = SPACING_WEIGHT_RST;
            restart_line();
            line_reports_due.delete();
            mismatches    = 0;
            pending       = 0;
            lines_checked = 0;
            best_updates  = 0;
        end
        else
        begin
            // Results are retired before the input of the same edge is taken in.
            if (result.valid && result.ready)
            begin
                if (line_reports_due.size() == 0)
                begin
                    flag_mismatch("result with no line outstanding", result.best_score, 0);
                end
                else
                begin
                    want = line_reports_due.pop_front();
                    if (result.found !== want.found)
                        flag_mismatch("found", result.found, want.found);
                    if (result.first_pos !== want.first_pos)
                        flag_mismatch("first_pos", result.first_pos, want.first_pos);
                    if (result.second_pos !== want.second_pos)
                        flag_mismatch("second_pos", result.second_pos, want.second_pos);
                    if (result.third_pos !== want.third_pos)
                        flag_mismatch("third_pos", result.third_pos, want.third_pos);
                    if (result.best_score !== want.best_score)
                        flag_mismatch("best_score", result.best_score, want.best_score);
                    lines_checked++;
                end
            end
            if (cfg_we)
            begin
                case (sed_reg_idx_t'(cfg_index))
                    REG_EDGE_THRESHOLD: thresh_reg = cfg_data;
                    REG_MEAN_GAIN:      gain_reg   = cfg_data;
                    REG_SPACING_WEIGHT: weight_reg = cfg_data;
                    default:            ;
                endcase
            end
            if (pixels.valid && pixels.ready)
                advance_scanline(pixels.sample, pixels.last);
            pending = line_reports_due.size();
        end
    end

endmodule

@@ bench/scanline_edge_triple_detector_tb.sv @@
// Stimulus, clocking and verdict for the scan-line edge triple detector regression.
module scanline_edge_triple_detector_tb;
    import sed_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling for a run of about a thousand requests.
    localparam int CYCLE_LIMIT = 500000;
    // Covers the longest request, a trailing sample with no result.
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS = 135;
    localparam int PHASES = 6;

    typedef logic [SAMPLE_W-1:0] pixel_row_t[$];

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int pending;
    int lines_checked;
    int best_updates;
    int items_sent = 0;
    int burst_left = 1;
    int cycle_count = 0;

    sed_in_if  pixels_ch ();
    sed_out_if result_ch ();

    scanline_edge_triple_detector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    triple_verdict_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixels        (pixels_ch),
        .result        (result_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .lines_checked (lines_checked),
        .best_updates  (best_updates)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a run that hangs on a handshake ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d reports outstanding",
                     cycle_count, pending);
            $display("scanline_edge_triple_detector regression: fail");
            $finish;
        end
    end

    // The result consumer stalls on a pattern of its own: spans of constant readiness,
    // spans of coin-toss readiness and spans where it is mostly stalled.
    initial
    begin : result_consumer
        int mode;
        int span;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 80);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    default: result_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offers one request and returns at the edge where it is taken. Readiness is
    // sampled at the falling edge, so the decision never races the rising edge.
    // Afterwards the sender may close its burst and sit out a gap.
    task automatic push_pixel(input logic [SAMPLE_W-1:0] sample, input logic last);
        logic taken;
        int   gap;
        pixels_ch.valid  <= 1'b1;
        pixels_ch.sample <= sample;
        pixels_ch.last   <= last;
        do
        begin
            @(negedge clk);
            taken = pixels_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            pixels_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            // Now and then a long burst with no gaps at all.
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(30, 80);
            else
                burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic send_line(input pixel_row_t row);
        for (int i = 0; i < row.size(); i++)
            push_pixel(row[i], i == row.size() - 1);
    endtask

    // Holds the sender back until every line report has come back, then lets the
    // block finish any request that causes no report.
    task automatic drain_reports(input int extra);
        pixels_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Registers are only touched with the block idle, one write per edge.
    task automatic program_regs(input logic [CFG_W-1:0] thresh, input logic [CFG_W-1:0] gain,
                                input logic [CFG_W-1:0] weight);
        drain_reports(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_index <= REG_EDGE_THRESHOLD;
        cfg_data  <= thresh;
        @(posedge clk);
        cfg_index <= REG_MEAN_GAIN;
        cfg_data  <= gain;
        @(posedge clk);
        cfg_index <= REG_SPACING_WEIGHT;
        cfg_data  <= weight;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // A well-formed line: a flat seed, then evenly spaced pulses against a background,
    // with the odd jitter in the spacing so that some triples are penalised.
    function automatic pixel_row_t make_pulse_line();
        pixel_row_t row;
        int lo;
        int hi;
        int val;
        int period;
        int pulses;
        int run;
        if ($urandom_range(0, 3) == 0)
        begin
            lo = $urandom_range(0, 1) ? 255 : 0;
            hi = 255 - lo;
        end
        else
        begin
            lo = $urandom_range(0, 255);
            hi = $urandom_range(0, 255);
        end
        for (int i = 0; i < SEED_LEN; i++)
        begin
            val = lo + $urandom_range(0, 3);
            if (val > 255)
                val = lo - $urandom_range(0, 3);
            row.insert(row.size(), SAMPLE_W'(val));
        end
        period = $urandom_range(1, 5);
        pulses = $urandom_range(2, 9);
        for (int p = 0; p < pulses; p++)
        begin
            run = period;
            if ($urandom_range(0, 9) == 0)
                run += $urandom_range(0, 2);
            repeat (run) row.insert(row.size(), SAMPLE_W'(lo));
            run = $urandom_range(1, 2);
            repeat (run) row.insert(row.size(), SAMPLE_W'(hi));
        end
        run = $urandom_range(0, 3);
        repeat (run) row.insert(row.size(), SAMPLE_W'(lo));
        return row;
    endfunction

    // Mostly well-formed lines, the rest cut short, pure noise or ending in the seed.
    function automatic pixel_row_t make_random_line();
        pixel_row_t row;
        int pick;
        int len;
        pick = $urandom_range(0, 19);
        if (pick < 14)
        begin
            row = make_pulse_line();
        end
        else if (pick < 16)
        begin
            row = make_pulse_line();
            len = $urandom_range(1, row.size());
            row = row[0:len-1];
        end
        else
        begin
            len = (pick < 18) ? $urandom_range(5, 40) : $urandom_range(1, SEED_LEN);
            repeat (len) row.insert(row.size(), SAMPLE_W'($urandom_range(0, 255)));
        end
        return row;
    endfunction

    initial
    begin : stimulus
        pixel_row_t row;
        int thresh_set[PHASES];
        int gain_set[PHASES];
        int weight_set[PHASES];
        int phase_items;

        pixels_ch.valid  <= 1'b0;
        pixels_ch.sample <= '0;
        pixels_ch.last   <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_EDGE_THRESHOLD;
        cfg_data         <= '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset defaults: a single-sample line, a line that
        // ends inside the seed with extreme values, and a plain pulse line.
        row = {8'd7};
        send_line(row);
        row = {8'd0, 8'd255, 8'd0, 8'd255};
        send_line(row);
        row = {8'd100, 8'd100, 8'd100, 8'd100, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        send_line(row);

        // Highest threshold, frozen mean, no spacing penalty: full-scale pulses give
        // the largest possible score, and the second equal triple must not displace
        // the first.
        program_regs(8'd255, 8'd0, 8'd0);
        row = {8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        send_line(row);

        // Random phases, the extremes among them.
        thresh_set = '{40, 0, 255, 60, 0, 127};
        gain_set   = '{77, 255, 0, 0, 0, 0};
        weight_set = '{2, 255, 0, 0, 0, 20};
        thresh_set[4] = $urandom_range(10, 90);
        gain_set[4]   = $urandom_range(0, 255);
        weight_set[4] = $urandom_range(0, 8);
        gain_set[5]   = $urandom_range(0, 255);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            program_regs(CFG_W'(thresh_set[ph]), CFG_W'(gain_set[ph]), CFG_W'(weight_set[ph]));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                row = make_random_line();
                send_line(row);
                phase_items += row.size();
                if ($urandom_range(0, 9) == 0)
                    drain_reports(0);
            end
        end

        drain_reports(30);

        $display("sent %0d pixel requests across %0d line reports and %0d register settings",
                 items_sent, lines_checked, PHASES + 2);
        $display("best triple replaced %0d times; mismatches %0d", best_updates, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("scanline_edge_triple_detector regression: pass");
        else
            $display("scanline_edge_triple_detector regression: fail");
        $finish;
    end

endmodule
